// ===== rtl/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants of the JSON string unescaper
// Byte codes, parse modes and the classified token passed front to back.
// ----------------------------------------------------------------------------
package jsu_pkg;

    localparam int JSU_BARE_CAPACITY = 64;
    localparam int JSU_QUEUE_DEPTH   = 4;

    // byte codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_BS_CTL = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_F   = 8'h46;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LO_A   = 8'h61;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_F   = 8'h66;
    localparam logic [7:0] CH_LO_N   = 8'h6E;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_T   = 8'h74;
    localparam logic [7:0] CH_LO_U   = 8'h75;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic [1:0] HEX_LAST  = 2'd3;

    typedef enum logic [2:0] {
        MODE_SKIP   = 3'd0,
        MODE_BARE   = 3'd1,
        MODE_QUOTED = 3'd2,
        MODE_ESCAPE = 3'd3,
        MODE_HEX    = 3'd4,
        MODE_DONE   = 3'd5
    } t_mode;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       begins_value;
        logic       is_ws;
        logic       is_quote;
        logic       is_bslash;
        logic       is_nul;
        logic       is_lf;
        logic       is_term;
        logic       is_u;
        logic       hex_ok;
        logic [3:0] hex_val;
        logic [7:0] esc_char;
    } t_token;

endpackage

// ===== rtl/jsu_if.sv =====
// ----------------------------------------------------------------------------
// jsu_if: stream channels of the JSON string unescaper
// Input text beats and output result beats, valid/ready handshake.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       begins_value;

    modport source (output valid, output text_byte, output begins_value, input ready);
    modport sink   (input valid, input text_byte, input begins_value, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       char_valid;
    logic       finished;
    logic       good;

    modport source (output valid, output out_char, output char_valid, output finished,
                    output good, input ready);
    modport sink   (input valid, input out_char, input char_valid, input finished,
                    input good, output ready);
endinterface

// ===== rtl/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front: input byte classifier
// Accepts text beats while the queue has room and tags each byte.
// ----------------------------------------------------------------------------
module jsu_front (
    jsu_in_if.sink          i_text,
    input  logic            i_full,
    output logic            o_push,
    output jsu_pkg::t_token o_tok
);
    import jsu_pkg::*;

    logic [7:0] b;

    assign b              = i_text.text_byte;
    assign i_text.ready   = !i_full;
    assign o_push         = i_text.valid && !i_full;

    always_comb begin
        o_tok              = '0;
        o_tok.text_byte    = b;
        o_tok.begins_value = i_text.begins_value;
        o_tok.is_ws        = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_LF) || (b == CH_CR);
        o_tok.is_quote     = (b == CH_QUOTE);
        o_tok.is_bslash    = (b == CH_BSLASH);
        o_tok.is_nul       = (b == CH_NUL);
        o_tok.is_lf        = (b == CH_LF);
        o_tok.is_term      = (b == CH_NUL) || (b == CH_COMMA) || (b == CH_RBRACE)
                             || (b == CH_RBRACK);
        o_tok.is_u         = (b == CH_LO_U);

        if (b >= CH_ZERO && b <= CH_NINE) begin
            o_tok.hex_ok  = 1'b1;
            o_tok.hex_val = 4'(b - CH_ZERO);
        end else if (b >= CH_LO_A && b <= CH_LO_F) begin
            o_tok.hex_ok  = 1'b1;
            o_tok.hex_val = 4'(b - CH_LO_A + 8'd10);
        end else if (b >= CH_UP_A && b <= CH_UP_F) begin
            o_tok.hex_ok  = 1'b1;
            o_tok.hex_val = 4'(b - CH_UP_A + 8'd10);
        end

        case (b)
            CH_LO_N: o_tok.esc_char = CH_LF;
            CH_LO_R: o_tok.esc_char = CH_CR;
            CH_LO_T: o_tok.esc_char = CH_TAB;
            CH_LO_B: o_tok.esc_char = CH_BS_CTL;
            CH_LO_F: o_tok.esc_char = CH_FF;
            default: o_tok.esc_char = b;
        endcase
    end

endmodule

// ===== rtl/jsu_queue.sv =====
// ----------------------------------------------------------------------------
// jsu_queue: token queue between classifier and parser
// Small register FIFO; lets each side stall on its own.
// ----------------------------------------------------------------------------
module jsu_queue #(
    parameter int DEPTH = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  jsu_pkg::t_token i_data,
    input  logic            i_pop,
    output jsu_pkg::t_token o_data,
    output logic            o_full,
    output logic            o_empty
);
    import jsu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_token           r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr, n_rd_ptr;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count out of range");

endmodule

// ===== rtl/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back: value parser and result register
// Walks the parse state machine one token per cycle unless the held result beat stalls.
// ----------------------------------------------------------------------------
module jsu_back #(
    parameter int BARE_CAPACITY = jsu_pkg::JSU_BARE_CAPACITY
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  jsu_pkg::t_token i_tok,
    input  logic            i_tok_valid,
    output logic            o_pop,
    jsu_out_if.source       o_result
);
    import jsu_pkg::*;

    localparam int LEN_W = $clog2(BARE_CAPACITY);
    localparam logic [LEN_W:0] LEN_FULL = (LEN_W + 1)'(BARE_CAPACITY - 1);

    t_mode            r_mode, n_mode;
    logic [1:0]       r_hexn, n_hexn;
    logic [15:0]      r_cp, n_cp;
    logic             r_err, n_err;
    logic [LEN_W-1:0] r_len, n_len;

    logic             r_out_valid;
    logic [7:0]       r_out_char;
    logic             r_out_cv, r_out_fin, r_out_good;

    // per-token decode
    t_mode            e_mode;
    logic [1:0]       e_hexn;
    logic [15:0]      e_cp, cp_next;
    logic             e_err;
    logic [LEN_W-1:0] e_len;
    logic [LEN_W:0]   len_inc;
    logic             emit, res_cv, res_fin, res_ok;
    logic [7:0]       res_char;

    // advance when the result slot is free or being drained
    assign o_pop = i_tok_valid && (!r_out_valid || o_result.ready);

    always_comb begin
        // a new value clears the parse state before its first byte
        e_mode  = i_tok.begins_value ? MODE_SKIP : r_mode;
        e_hexn  = i_tok.begins_value ? 2'd0 : r_hexn;
        e_cp    = i_tok.begins_value ? 16'd0 : r_cp;
        e_err   = i_tok.begins_value ? 1'b0 : r_err;
        e_len   = i_tok.begins_value ? '0 : r_len;
        len_inc = {1'b0, e_len} + 1'b1;
        cp_next = {e_cp[11:0], i_tok.hex_val};

        n_mode   = e_mode;
        n_hexn   = e_hexn;
        n_cp     = e_cp;
        n_err    = e_err;
        n_len    = e_len;
        emit     = 1'b0;
        res_cv   = 1'b0;
        res_fin  = 1'b0;
        res_ok   = 1'b0;
        res_char = '0;

        unique case (e_mode)
            MODE_SKIP, MODE_BARE: begin
                if (e_mode == MODE_SKIP && i_tok.is_ws) begin
                    // drop leading whitespace
                end else if (e_mode == MODE_SKIP && i_tok.is_quote) begin
                    n_mode = MODE_QUOTED;
                end else if (i_tok.is_term) begin
                    emit    = 1'b1;
                    res_fin = 1'b1;
                    res_ok  = (e_len != '0);
                end else begin
                    n_mode   = MODE_BARE;
                    n_len    = len_inc[LEN_W-1:0];
                    emit     = 1'b1;
                    res_cv   = 1'b1;
                    res_char = i_tok.text_byte;
                    if (len_inc >= LEN_FULL) begin
                        res_fin = 1'b1;
                        res_ok  = 1'b1;
                    end
                end
            end
            MODE_QUOTED: begin
                if (i_tok.is_nul || i_tok.is_lf) begin
                    emit    = 1'b1;
                    res_fin = 1'b1;
                end else if (i_tok.is_quote) begin
                    emit    = 1'b1;
                    res_fin = 1'b1;
                    res_ok  = !e_err;
                end else if (i_tok.is_bslash) begin
                    n_mode = MODE_ESCAPE;
                end else begin
                    emit     = 1'b1;
                    res_cv   = 1'b1;
                    res_char = i_tok.text_byte;
                end
            end
            MODE_ESCAPE: begin
                if (i_tok.is_nul) begin
                    emit    = 1'b1;
                    res_fin = 1'b1;
                end else if (i_tok.is_u) begin
                    n_mode = MODE_HEX;
                    n_hexn = 2'd0;
                    n_cp   = 16'd0;
                end else begin
                    n_mode   = MODE_QUOTED;
                    emit     = 1'b1;
                    res_cv   = 1'b1;
                    res_char = i_tok.esc_char;
                end
            end
            MODE_HEX: begin
                if (i_tok.is_nul) begin
                    emit    = 1'b1;
                    res_fin = 1'b1;
                end else if (!i_tok.hex_ok) begin
                    n_err    = 1'b1;
                    n_mode   = MODE_QUOTED;
                    emit     = 1'b1;
                    res_cv   = 1'b1;
                    res_char = CH_QMARK;
                end else begin
                    n_cp = cp_next;
                    if (e_hexn == HEX_LAST) begin
                        n_hexn   = 2'd0;
                        n_mode   = MODE_QUOTED;
                        emit     = 1'b1;
                        res_cv   = 1'b1;
                        res_char = (cp_next[15:8] == 8'd0) ? cp_next[7:0] : CH_QMARK;
                    end else begin
                        n_hexn = e_hexn + 1'b1;
                    end
                end
            end
            MODE_DONE: begin
                // ignore bytes until the next value begins
            end
            default: begin
                n_mode = MODE_DONE;
            end
        endcase

        if (res_fin) begin
            n_mode = MODE_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_SKIP;
            r_hexn      <= '0;
            r_cp        <= '0;
            r_err       <= 1'b0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_mode      <= n_mode;
                r_hexn      <= n_hexn;
                r_cp        <= n_cp;
                r_err       <= n_err;
                r_len       <= n_len;
                r_out_valid <= emit;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && emit) begin
            r_out_char <= res_char;
            r_out_cv   <= res_cv;
            r_out_fin  <= res_fin;
            r_out_good <= res_ok;
        end
    end

    assign o_result.valid      = r_out_valid;
    assign o_result.out_char   = r_out_char;
    assign o_result.char_valid = r_out_cv;
    assign o_result.finished   = r_out_fin;
    assign o_result.good       = r_out_good;

    a_fin_to_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && emit && res_fin) |=> (r_mode == MODE_DONE))
        else $error("finish beat did not close the value");
    a_good_needs_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_fin || !r_out_good))
        else $error("good flag set on a beat that does not finish");
    a_char_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_cv) |-> (r_out_char == 8'd0))
        else $error("character set on a beat without one");

endmodule

// ===== rtl/json_string_unescaper.sv =====
// Path: each byte is queued, then decoded; a result beat it yields is registered.
// Throughput: one byte per cycle while the queue has room; the token queue of
//   QUEUE_DEPTH entries and the result register absorb output stalls, and the parser
//   takes one token per cycle while the result register is free or being drained.
// Reset (synchronous, active low): queue emptied, result register idle, parser in
//   whitespace skipping with all counters and the error flag cleared.
// ----------------------------------------------------------------------------
// json_string_unescaper: streaming JSON value unescaper
// Classifies text bytes, queues them and decodes quoted or bare values.
// ----------------------------------------------------------------------------
module json_string_unescaper #(
    parameter int BARE_CAPACITY = jsu_pkg::JSU_BARE_CAPACITY,
    parameter int QUEUE_DEPTH   = jsu_pkg::JSU_QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_text,
    jsu_out_if.source o_result
);
    import jsu_pkg::*;

    t_token push_tok, head_tok;
    logic   push, pop, full, empty;

    jsu_front u_front (
        .i_text (i_text),
        .i_full (full),
        .o_push (push),
        .o_tok  (push_tok)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_tok),
        .i_pop   (pop),
        .o_data  (head_tok),
        .o_full  (full),
        .o_empty (empty)
    );

    jsu_back #(
        .BARE_CAPACITY (BARE_CAPACITY)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tok       (head_tok),
        .i_tok_valid (!empty),
        .o_pop       (pop),
        .o_result    (o_result)
    );

endmodule

// ===== bench/json_string_unescaper_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescaper_tb: self-checking bench of the JSON string unescaper
// Feeds value text byte by byte under random gaps and output stalls.
// A behavioral decoder predicts every result beat, and the bench compares
// each beat taken from the block, in order, against the queue of decoded
// characters and finish statuses.
// ----------------------------------------------------------------------------
module json_string_unescaper_tb;
    import jsu_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 250;
    localparam int RANDOM_BYTES = 550;

    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       finished;
        logic       good;
    } result_t;

    logic i_clk;
    logic i_rst_n;

    jsu_in_if  text_if ();
    jsu_out_if result_if ();

    json_string_unescaper u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_text   (text_if),
        .o_result (result_if)
    );

    // decoder state, kept in step with the accepted byte stream
    t_mode       dec_mode;
    logic [1:0]  dec_hex_cnt;
    logic [15:0] dec_code;
    logic        dec_err;
    logic [5:0]  dec_bare_len;

    result_t     decoded_q[$];
    logic [7:0]  value_bytes[$];
    bit          value_first[$];

    int fail_count;
    int random_sent;
    int cycle_count = 0;
    bit src_gaps_on;
    bit sink_gaps_on;
    bit hold_request;

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d beats still expected", $time, decoded_q.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void clear_decoder();
        dec_mode     = MODE_SKIP;
        dec_hex_cnt  = '0;
        dec_code     = '0;
        dec_err      = 1'b0;
        dec_bare_len = '0;
    endfunction

    function automatic result_t make_beat(logic [7:0] ch, logic cv, logic fin, logic ok);
        result_t r;
        r.out_char   = cv ? ch : CH_NUL;
        r.char_valid = cv;
        r.finished   = fin;
        r.good       = fin & ok;
        if (fin)
            dec_mode = MODE_DONE;
        return r;
    endfunction

    function automatic int hex_nibble(logic [7:0] b);
        if (b >= CH_ZERO && b <= CH_NINE) return int'(b - CH_ZERO);
        if (b >= CH_LO_A && b <= CH_LO_F) return int'(b - CH_LO_A) + 10;
        if (b >= CH_UP_A && b <= CH_UP_F) return int'(b - CH_UP_A) + 10;
        return -1;
    endfunction

    function automatic bit is_bare_end(logic [7:0] b);
        return b == CH_NUL || b == CH_COMMA || b == CH_RBRACE || b == CH_RBRACK;
    endfunction

    function automatic bit is_ws(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_CR;
    endfunction

    function automatic result_t bare_step(logic [7:0] b);
        // terminator is not copied
        if (is_bare_end(b))
            return make_beat(CH_NUL, 1'b0, 1'b1, dec_bare_len != '0);
        dec_bare_len = dec_bare_len + 6'd1;
        if (int'(dec_bare_len) + 1 >= JSU_BARE_CAPACITY)
            return make_beat(b, 1'b1, 1'b1, 1'b1);
        return make_beat(b, 1'b1, 1'b0, 1'b0);
    endfunction

    // advance the decoder by one byte; return 1 when a result beat is due
    function automatic bit unescape_byte(input logic [7:0] b, input logic first,
                                         output result_t r);
        int nib;
        r = '0;
        if (first)
            clear_decoder();
        case (dec_mode)
            MODE_SKIP: begin
                if (is_ws(b))
                    return 1'b0;
                if (b == CH_QUOTE) begin
                    dec_mode = MODE_QUOTED;
                    return 1'b0;
                end
                dec_mode = MODE_BARE;
                r = bare_step(b);
                return 1'b1;
            end
            MODE_BARE: begin
                r = bare_step(b);
                return 1'b1;
            end
            MODE_QUOTED: begin
                if (b == CH_NUL || b == CH_LF) begin
                    r = make_beat(CH_NUL, 1'b0, 1'b1, 1'b0);
                end else if (b == CH_QUOTE) begin
                    r = make_beat(CH_NUL, 1'b0, 1'b1, !dec_err);
                end else if (b == CH_BSLASH) begin
                    dec_mode = MODE_ESCAPE;
                    return 1'b0;
                end else begin
                    r = make_beat(b, 1'b1, 1'b0, 1'b0);
                end
                return 1'b1;
            end
            MODE_ESCAPE: begin
                if (b == CH_NUL) begin
                    r = make_beat(CH_NUL, 1'b0, 1'b1, 1'b0);
                    return 1'b1;
                end
                dec_mode = MODE_QUOTED;
                case (b)
                    CH_LO_N: r = make_beat(CH_LF, 1'b1, 1'b0, 1'b0);
                    CH_LO_R: r = make_beat(CH_CR, 1'b1, 1'b0, 1'b0);
                    CH_LO_T: r = make_beat(CH_TAB, 1'b1, 1'b0, 1'b0);
                    CH_LO_B: r = make_beat(CH_BS_CTL, 1'b1, 1'b0, 1'b0);
                    CH_LO_F: r = make_beat(CH_FF, 1'b1, 1'b0, 1'b0);
                    CH_LO_U: begin
                        dec_mode    = MODE_HEX;
                        dec_hex_cnt = '0;
                        dec_code    = '0;
                        return 1'b0;
                    end
                    default: r = make_beat(b, 1'b1, 1'b0, 1'b0);
                endcase
                return 1'b1;
            end
            MODE_HEX: begin
                if (b == CH_NUL) begin
                    r = make_beat(CH_NUL, 1'b0, 1'b1, 1'b0);
                    return 1'b1;
                end
                nib = hex_nibble(b);
                if (nib < 0) begin
                    dec_err  = 1'b1;
                    dec_mode = MODE_QUOTED;
                    r = make_beat(CH_QMARK, 1'b1, 1'b0, 1'b0);
                    return 1'b1;
                end
                dec_code = {dec_code[11:0], nib[3:0]};
                if (dec_hex_cnt == HEX_LAST) begin
                    dec_hex_cnt = '0;
                    dec_mode    = MODE_QUOTED;
                    r = make_beat(dec_code < 16'd256 ? dec_code[7:0] : CH_QMARK,
                                  1'b1, 1'b0, 1'b0);
                    return 1'b1;
                end
                dec_hex_cnt = dec_hex_cnt + 2'd1;
                return 1'b0;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic first);
        int      gap;
        result_t beat;
        gap = src_gaps_on ? pick_gap() : 0;
        if (gap > 0) begin
            text_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        text_if.valid        <= 1'b1;
        text_if.text_byte    <= b;
        text_if.begins_value <= first;
        forever begin
            @(posedge i_clk);
            if (text_if.ready)
                break;
        end
        if (unescape_byte(b, first, beat))
            decoded_q.push_back(beat);
    endtask

    task automatic send_text(input string s, input bit first);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i], first && i == 0);
    endtask

    function automatic void push_byte(logic [7:0] b, bit first);
        value_bytes.push_back(b);
        value_first.push_back(first);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        bit upper;
        upper = $urandom_range(0, 1);
        if (n < 4'd10) return CH_ZERO + 8'(n);
        return (upper ? CH_UP_A : CH_LO_A) + 8'(n) - 8'd10;
    endfunction

    function automatic logic [7:0] pick_ws();
        case ($urandom_range(0, 3))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] pick_bad_hex();
        logic [7:0] b;
        do b = 8'($urandom_range(1, 255)); while (hex_nibble(b) >= 0);
        return b;
    endfunction

    task automatic send_value();
        for (int i = 0; i < value_bytes.size(); i++)
            send_byte(value_bytes[i], value_first[i]);
        random_sent += value_bytes.size();
        value_bytes.delete();
        value_first.delete();
    endtask

    // mostly well-formed values with random content, some noise
    task automatic build_random_value();
        int          kind;
        int          n;
        int          k;
        logic [7:0]  b;
        logic [15:0] code;
        push_byte(CH_NUL, 1'b1);
        value_bytes.delete();
        value_first.delete();
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) push_byte(pick_ws(), 1'b0);
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
            push_byte(CH_QUOTE, 1'b0);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 30) : $urandom_range(0, 8);
            repeat (n) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: begin
                        do b = 8'($urandom_range(1, 255));
                        while (b == CH_QUOTE || b == CH_BSLASH || b == CH_LF);
                        push_byte(b, 1'b0);
                    end
                    5, 6: begin
                        push_byte(CH_BSLASH, 1'b0);
                        case ($urandom_range(0, 8))
                            0: b = CH_LO_N;
                            1: b = CH_LO_R;
                            2: b = CH_LO_T;
                            3: b = CH_LO_B;
                            4: b = CH_LO_F;
                            5: b = CH_QUOTE;
                            6: b = CH_BSLASH;
                            7: b = "/";
                            default: begin
                                do b = 8'($urandom_range(1, 255)); while (b == CH_LO_U);
                            end
                        endcase
                        push_byte(b, 1'b0);
                    end
                    7, 8: begin
                        push_byte(CH_BSLASH, 1'b0);
                        push_byte(CH_LO_U, 1'b0);
                        code = $urandom_range(0, 1) ? 16'($urandom_range(0, 255))
                                                    : 16'($urandom_range(0, 65535));
                        for (int d = 3; d >= 0; d--)
                            push_byte(hex_char(code[d*4 +: 4]), 1'b0);
                    end
                    default: begin
                        push_byte(CH_BSLASH, 1'b0);
                        push_byte(CH_LO_U, 1'b0);
                        k = $urandom_range(0, 3);
                        repeat (k) push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
                        push_byte(pick_bad_hex(), 1'b0);
                    end
                endcase
            end
            case ($urandom_range(0, 9))
                7: push_byte(CH_NUL, 1'b0);
                8: push_byte(CH_LF, 1'b0);
                9: begin
                    // cut the text inside an escape
                    push_byte(CH_BSLASH, 1'b0);
                    if ($urandom_range(0, 1)) begin
                        push_byte(CH_LO_U, 1'b0);
                        repeat ($urandom_range(0, 3))
                            push_byte(hex_char(4'($urandom_range(0, 15))), 1'b0);
                    end
                    push_byte(CH_NUL, 1'b0);
                end
                default: push_byte(CH_QUOTE, 1'b0);
            endcase
        end else if (kind < 80) begin
            n = ($urandom_range(0, 7) == 0) ? $urandom_range(58, 70) : $urandom_range(0, 8);
            for (int i = 0; i < n; i++) begin
                do b = 8'($urandom_range(1, 255));
                while (is_bare_end(b) || (i == 0 && (is_ws(b) || b == CH_QUOTE)));
                push_byte(b, 1'b0);
            end
            case ($urandom_range(0, 3))
                0: push_byte(CH_NUL, 1'b0);
                1: push_byte(CH_COMMA, 1'b0);
                2: push_byte(CH_RBRACE, 1'b0);
                default: push_byte(CH_RBRACK, 1'b0);
            endcase
        end else if (kind < 88) begin
            push_byte(CH_NUL, 1'b0);
        end else begin
            // noise, with value starts falling anywhere
            repeat ($urandom_range(1, 8))
                push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        end
        // bytes after the finish are dropped by the block
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
        value_first[0] = 1'b1;
    endtask

    task automatic test_quoted_escapes();
        send_text(" \"a\\n\\u00FF\"", 1'b1);
    endtask

    task automatic test_end_of_text();
        send_byte(CH_NUL, 1'b1);
        send_text("\"\\uz\\", 1'b1);
        send_byte(CH_NUL, 1'b0);
        send_text("\"\\u12", 1'b1);
        send_byte(CH_NUL, 1'b0);
    endtask

    task automatic test_bare_terminators();
        send_text("x]", 1'b1);
        send_byte(8'hFF, 1'b0);
        send_text("7,", 1'b1);
        send_text("}", 1'b1);
    endtask

    task automatic test_output_hold();
        logic [7:0] b;
        hold_request = 1'b1;
        src_gaps_on  = 1'b0;
        push_byte(CH_QUOTE, 1'b1);
        repeat (40) begin
            do b = 8'($urandom_range(1, 255));
            while (b == CH_QUOTE || b == CH_BSLASH || b == CH_LF);
            push_byte(b, 1'b0);
        end
        push_byte(CH_QUOTE, 1'b0);
        send_value();
        src_gaps_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        repeat (15) begin
            build_random_value();
            send_value();
        end
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
    endtask

    task automatic test_random_values();
        while (random_sent < RANDOM_BYTES) begin
            build_random_value();
            send_value();
        end
    endtask

    initial begin : sink_ready
        int stall_left;
        int hold_left;
        stall_left      = 0;
        hold_left       = 0;
        result_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                result_if.ready <= 1'b0;
            end else begin
                result_if.ready <= 1'b1;
                if (sink_gaps_on && $urandom_range(0, 99) < 25)
                    stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        result_t got;
        result_t want;
        if (i_rst_n && result_if.valid && result_if.ready) begin
            got = {result_if.out_char, result_if.char_valid, result_if.finished,
                   result_if.good};
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected beat: char %h cv %b fin %b good %b", $time,
                         got.out_char, got.char_valid, got.finished, got.good);
                fail_count++;
            end else begin
                want = decoded_q.pop_front();
                if (got !== want) begin
                    $display("%0t: expected char %h cv %b fin %b good %b", $time,
                             want.out_char, want.char_valid, want.finished, want.good);
                    $display("%0t: actual   char %h cv %b fin %b good %b", $time,
                             got.out_char, got.char_valid, got.finished, got.good);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        i_rst_n              = 1'b0;
        text_if.valid        = 1'b0;
        text_if.text_byte    = CH_NUL;
        text_if.begins_value = 1'b0;
        fail_count           = 0;
        random_sent          = 0;
        src_gaps_on          = 1'b1;
        sink_gaps_on         = 1'b1;
        hold_request         = 1'b0;
        clear_decoder();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_quoted_escapes();
        test_end_of_text();
        test_bare_terminators();
        test_output_hold();
        test_back_to_back();
        test_random_values();

        text_if.valid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
